// ----- src/clds_pkg.sv -----
// Shared constants, codes and types of the clause literal distinct sampler.
// Used by the cell row and by the top level; depends on nothing else.
package clds_pkg;

  // Store depth and variable width.
  localparam int unsigned MAX_CLAUSE_LEN = 32;
  localparam int unsigned VAR_BITS       = 20;

  // Derived widths.
  localparam int unsigned LIT_BITS  = VAR_BITS + 1;
  localparam int unsigned CLEN_W    = 6;
  localparam int unsigned CNT_W     = $clog2(MAX_CLAUSE_LEN + 1);
  localparam int unsigned CFG_W     = (VAR_BITS > CLEN_W) ? VAR_BITS : CLEN_W;
  localparam int unsigned SUM_W     = CFG_W + 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned S_DATA_W  = ((LIT_BITS + 7) / 8) * 8;
  localparam int unsigned M_DATA_W  = ((LIT_BITS + VAR_BITS + 7) / 8) * 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VAR_COUNT  = 1'b0,
    CFG_CLAUSE_LEN = 1'b1
  } cfg_reg_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_RANK = 2'd1,
    STATUS_BAD_LEN  = 2'd2
  } status_e;

  // Per-cell write control: load the cell, and take the left neighbor
  // (shift) rather than the new rank (insert).
  typedef struct packed {
    logic load;
    logic take_prev;
  } cell_ctl_t;

endpackage

// ----- src/clause_literal_distinct_sampler.sv -----
// Clause literal distinct sampler: maps a random rank to the rank-th unused
// variable of the current clause, using a row of compare and shift cells.
// A request is captured into the input registers; the compute step then loads its result
// into the output register once it is free, and no new request is taken until that step.
// Reset clears the counters, configuration and handshake state; store cells are
// not cleared, entries at or above the drawn count are never used.
module clause_literal_distinct_sampler
  import clds_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_DATA_W-1:0]  s_axis_tdata,  // raw_literal, then zero pad
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_DATA_W-1:0]  m_axis_tdata,  // literal, variable, then zero pad
  output logic                 m_axis_tlast,
  output logic [1:0]           m_axis_tuser   // status
);

  // Configuration registers.
  logic [VAR_BITS-1:0] var_count_q;
  logic [CLEN_W-1:0]   clen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_count_q <= '0;
      clen_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_VAR_COUNT:  var_count_q <= cfg_data_i[VAR_BITS-1:0];
        CFG_CLAUSE_LEN: clen_q      <= cfg_data_i[CLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input capture: magnitude and sign of the raw literal.
  logic                in_fire;
  logic                busy_q;
  logic                neg_q;
  logic [LIT_BITS-1:0] mag_q;
  logic [LIT_BITS-1:0] raw;

  assign raw           = s_axis_tdata[LIT_BITS-1:0];
  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      neg_q <= raw[LIT_BITS-1];
      mag_q <= raw[LIT_BITS-1] ? (LIT_BITS'(0) - raw) : raw;
    end
  end

  // Compute step runs once the output register can take the result.
  logic m_valid_q;
  logic step;

  assign step = busy_q && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
    end else if (step) begin
      busy_q <= 1'b0;
    end
  end

  // Request checks.
  logic [CNT_W-1:0] drawn_count_q;
  logic             len_bad;
  logic             rank_bad;
  logic             ok;
  status_e          status;

  assign len_bad = (SUM_W'(clen_q) > SUM_W'(var_count_q)) ||
                   (SUM_W'(clen_q) > SUM_W'(MAX_CLAUSE_LEN));
  assign rank_bad = (clen_q == '0) ||
                    (SUM_W'(drawn_count_q) >= SUM_W'(MAX_CLAUSE_LEN)) ||
                    (mag_q == '0) ||
                    ((SUM_W'(mag_q) + SUM_W'(drawn_count_q)) > SUM_W'(var_count_q));

  always_comb begin
    priority if (len_bad) begin
      status = STATUS_BAD_LEN;
    end else if (rank_bad) begin
      status = STATUS_BAD_RANK;
    end else begin
      status = STATUS_OK;
    end
  end

  assign ok = (status == STATUS_OK);

  // Cell row.
  logic [VAR_BITS-1:0]       rank;
  logic [VAR_BITS-1:0]       entry [MAX_CLAUSE_LEN];
  logic [VAR_BITS-1:0]       prev  [MAX_CLAUSE_LEN];
  logic [MAX_CLAUSE_LEN-1:0] le;
  logic [MAX_CLAUSE_LEN-1:0] le_m;
  cell_ctl_t                 cell_ctl [MAX_CLAUSE_LEN];
  logic [CNT_W-1:0]          pos;

  assign rank = mag_q[VAR_BITS-1:0];

  for (genvar gi = 0; gi < MAX_CLAUSE_LEN; gi++) begin : g_cell
    if (gi == 0) begin : g_first
      assign prev[gi] = '0;
    end else begin : g_rest
      assign prev[gi] = entry[gi-1];
    end

    // Only cells below the drawn count hold entries of this clause.
    assign le_m[gi] = le[gi] && (CNT_W'(gi) < drawn_count_q);

    assign cell_ctl[gi].load      = step && ok && (CNT_W'(gi) >= pos);
    assign cell_ctl[gi].take_prev = (CNT_W'(gi) > pos);

    clds_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[gi]),
      .rank_i  (rank),
      .prev_i  (prev[gi]),
      .entry_o (entry[gi]),
      .le_o    (le[gi])
    );
  end

  // Insert point: first cell whose masked compare is false.
  always_comb begin
    pos = CNT_W'(MAX_CLAUSE_LEN);
    for (int i = MAX_CLAUSE_LEN - 1; i >= 0; i--) begin
      if (!le_m[i]) begin
        pos = CNT_W'(i);
      end
    end
  end

  // Chosen variable, literal and clause end.
  logic [VAR_BITS-1:0] var_sel;
  logic [LIT_BITS-1:0] lit_sel;
  logic                last;

  assign var_sel = rank + VAR_BITS'(pos);
  assign lit_sel = neg_q ? (LIT_BITS'(0) - LIT_BITS'(var_sel)) : LIT_BITS'(var_sel);
  assign last    = (SUM_W'(drawn_count_q) + SUM_W'(1)) >= SUM_W'(clen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drawn_count_q <= '0;
    end else if (step && ok) begin
      drawn_count_q <= last ? '0 : (drawn_count_q + CNT_W'(1));
    end
  end

  // Output register.
  logic [LIT_BITS-1:0] lit_q;
  logic [VAR_BITS-1:0] var_q;
  logic                last_q;
  status_e             status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (step) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      lit_q    <= ok ? lit_sel : '0;
      var_q    <= ok ? var_sel : '0;
      last_q   <= ok && last;
      status_q <= status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_DATA_W'({var_q, lit_q});
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = status_q;

`ifndef SYNTHESIS
  // The drawn count never reaches the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drawn_count_q < CNT_W'(MAX_CLAUSE_LEN))
    else $error("drawn count reached store depth");

  // A dropped item carries zero payload and no clause end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (status_q != STATUS_OK)) |-> ((lit_q == '0) && (var_q == '0) && !last_q))
    else $error("dropped item carries payload");

  // An accepted literal names a nonzero variable with matching magnitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (status_q == STATUS_OK)) |->
      ((var_q != '0) && ((lit_q == LIT_BITS'(var_q)) ||
                         (lit_q == (LIT_BITS'(0) - LIT_BITS'(var_q))))))
    else $error("literal does not match variable");

  // A new result only follows a compute step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(busy_q))
    else $error("result without a pending request");
`endif

endmodule

// ----- src/clds_cell.sv -----
// One cell of the sorted store: holds one drawn variable as (variable - index).
// Depends on clds_pkg for widths and the cell control struct.
module clds_cell
  import clds_pkg::*;
(
  input  logic                clk_i,
  input  cell_ctl_t           ctl_i,
  input  logic [VAR_BITS-1:0] rank_i,
  input  logic [VAR_BITS-1:0] prev_i,
  output logic [VAR_BITS-1:0] entry_o,
  output logic                le_o
);

  logic [VAR_BITS-1:0] entry_q;
  logic [VAR_BITS-1:0] entry_d;

  // Offset entries are nondecreasing along the row, so the compare
  // results form a thermometer code.
  assign le_o = (entry_q <= rank_i);

  // A shifted entry moves one index up, so its offset drops by one.
  // An inserted entry has offset equal to the rank itself.
  assign entry_d = ctl_i.take_prev ? (prev_i - VAR_BITS'(1)) : rank_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule
